// File: design/bscfn_pkg.sv
`timescale 1ns / 1ps

package bscfn_pkg;

  localparam int IdxW  = 12;
  localparam int WordW = 64;
  localparam int BitW  = 6;   // bit position inside a word
  localparam int WselW = IdxW - BitW;

  typedef enum logic [2:0] {
    KindTest       = 3'd0,
    KindSet        = 3'd1,
    KindClear      = 3'd2,
    KindFind       = 3'd3,
    KindFindCommon = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StBitRd,
    StBitWb,
    StScan,
    StDone
  } state_e;

  // Memory port controls: a read enable shared by both maps and a write enable for each map
  typedef struct packed {
    logic rd_en;
    logic wr_first;
    logic wr_second;
  } mem_ctl_t;

  // Lowest set bit by halving; an all-zero word gives 63
  function automatic logic [BitW-1:0] low_one(logic [WordW-1:0] w);
    logic [WordW-1:0] v;
    logic [BitW-1:0]  n;
    v = w;
    n = '0;
    for (int k = BitW - 1; k >= 0; k--) begin
      if ((v & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0) begin
        n[k] = 1'b1;
        v    = v >> (1 << k);
      end
    end
    return n;
  endfunction

endpackage

// File: design/bscfn_if.sv
`timescale 1ns / 1ps

interface bscfn_in_if
  import bscfn_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [2:0]      kind;
  logic            map_select;
  logic [IdxW-1:0] bit_index;
  logic [IdxW-1:0] last_index;

  modport source (output valid, kind, map_select, bit_index, last_index, input ready);
  modport sink   (input valid, kind, map_select, bit_index, last_index, output ready);
endinterface

interface bscfn_out_if
  import bscfn_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            old_bit;
  logic            found;
  logic [IdxW-1:0] position;

  modport source (output valid, old_bit, found, position, input ready);
  modport sink   (input valid, old_bit, found, position, output ready);
endinterface

// File: design/bitmap_set_clear_find_next.sv
`timescale 1ns / 1ps

// Channel  | Role   | Payload                                     | Transaction
// ---------+--------+---------------------------------------------+-------------------------
// in_i     | sink   | kind, map_select, bit_index, last_index     | valid & ready at clk_i
// out_o    | source | old_bit, found, position                    | valid & ready at clk_i
//
// Test, set and clear go from accept to result through word read, write-back and
// result load; the word memory read port is synchronous, hence the separate read step.
// A search reads one word per cycle up to the end word, stopping at the first hit.
// After reset the block clears both maps, one word per cycle, all MAP_BITS/64 words
// (rounded up), with in_i.ready low. One item is in work at a time; a result
// waiting on out_o does not stop the next item from being accepted.

module bitmap_set_clear_find_next
  import bscfn_pkg::*;
#(
  parameter int MAP_BITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bscfn_in_if.sink    in_i,
  bscfn_out_if.source out_o
);

  localparam int MapWords = (MAP_BITS + 63) / 64;
  localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;

  state_e            state_q, state_d;
  logic [2:0]        kind_q, kind_d;
  logic              sel_q, sel_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   last_q, last_d;       // clamped last index
  logic [WselW:0]    ptr_q, ptr_d;         // next word to read in a scan
  logic              pend_q, pend_d;       // read data of pword_q arrives now
  logic [WselW-1:0]  pword_q, pword_d;
  logic [AddrW-1:0]  clr_q, clr_d;

  logic              res_old_q, res_old_d;
  logic              res_found_q, res_found_d;
  logic [IdxW-1:0]   res_pos_q, res_pos_d;

  logic              out_valid_q, out_valid_d;
  logic              out_old_q, out_old_d;
  logic              out_found_q, out_found_d;
  logic [IdxW-1:0]   out_pos_q, out_pos_d;

  mem_ctl_t          mem_ctl;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic [WordW-1:0]  wr_data;
  logic [WordW-1:0]  first_word;
  logic [WordW-1:0]  second_word;

  logic              in_fire;
  logic              out_fire;
  logic              res_load;
  logic [IdxW-1:0]   in_last_c;
  logic              in_idx_ok;
  logic              in_range_ok;
  logic              is_bit_op;
  logic              is_find;

  logic [WordW-1:0]  sel_word;
  logic [WordW-1:0]  bit_mask;
  logic              is_update;
  logic              scan_issue;
  logic [WordW-1:0]  scan_word;
  logic              scan_hit;
  logic              scan_end;
  logic [IdxW-1:0]   scan_pos;

  bscfn_store #(
    .WORDS  (MapWords),
    .ADDR_W (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .first_o   (first_word),
    .second_o  (second_word)
  );

  // Handshakes
  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_valid_q & out_o.ready;
  assign res_load   = (state_q == StDone) & (~out_valid_q | out_o.ready);

  // Input decode: clamp the last index to the top of the map
  assign in_last_c   = (32'(in_i.last_index) > MAP_BITS - 1) ? IdxW'(MAP_BITS - 1)
                                                             : in_i.last_index;
  assign in_idx_ok   = 32'(in_i.bit_index) < MAP_BITS;
  assign in_range_ok = in_i.bit_index <= in_last_c;
  assign is_bit_op   = (in_i.kind == KindTest) | (in_i.kind == KindSet) |
                       (in_i.kind == KindClear);
  assign is_find     = (in_i.kind == KindFind) | (in_i.kind == KindFindCommon);

  // Bit update path: data of the addressed word is on the read port in StBitWb
  assign sel_word  = sel_q ? second_word : first_word;
  assign bit_mask  = 64'd1 << idx_q[BitW-1:0];
  assign is_update = (kind_q == KindSet) | (kind_q == KindClear);

  // Scan path: issue reads up to the end word, check each word as its read data returns
  assign scan_issue = ptr_q <= {1'b0, last_q[IdxW-1:BitW]};
  always_comb begin
    scan_word = first_word;
    if (kind_q == KindFindCommon) begin
      scan_word = scan_word & second_word;
    end
    if (pword_q == idx_q[IdxW-1:BitW]) begin
      scan_word = scan_word & ({WordW{1'b1}} << idx_q[BitW-1:0]);
    end
  end
  assign scan_hit = pend_q & (scan_word != '0);
  assign scan_end = pend_q & (pword_q == last_q[IdxW-1:BitW]);
  assign scan_pos = {pword_q, low_one(scan_word)};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_q == AddrW'(MapWords - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          if (is_bit_op && in_idx_ok) begin
            state_d = StBitRd;
          end else if (is_find && in_range_ok) begin
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end
      end
      StBitRd: state_d = StBitWb;
      StBitWb: state_d = StDone;
      StScan: begin
        if (scan_hit || scan_end) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Memory controls
  always_comb begin
    mem_ctl = '0;
    rd_addr = AddrW'(idx_q[IdxW-1:BitW]);
    wr_addr = AddrW'(idx_q[IdxW-1:BitW]);
    wr_data = (kind_q == KindSet) ? (sel_word | bit_mask) : (sel_word & ~bit_mask);
    unique case (state_q)
      StClear: begin
        mem_ctl.wr_first  = 1'b1;
        mem_ctl.wr_second = 1'b1;
        wr_addr           = clr_q;
        wr_data           = '0;
      end
      StBitRd: mem_ctl.rd_en = 1'b1;
      StBitWb: begin
        mem_ctl.wr_first  = is_update & ~sel_q;
        mem_ctl.wr_second = is_update & sel_q;
      end
      StScan: begin
        mem_ctl.rd_en = scan_issue;
        rd_addr       = AddrW'(ptr_q);
      end
      default: ;
    endcase
  end

  // Item registers and result
  always_comb begin
    kind_d      = kind_q;
    sel_d       = sel_q;
    idx_d       = idx_q;
    last_d      = last_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pword_d     = pword_q;
    clr_d       = clr_q;
    res_old_d   = res_old_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;

    if (state_q == StClear) begin
      clr_d = clr_q + AddrW'(1);
    end

    if (in_fire) begin
      kind_d      = in_i.kind;
      sel_d       = in_i.map_select;
      idx_d       = in_i.bit_index;
      last_d      = in_last_c;
      ptr_d       = {1'b0, in_i.bit_index[IdxW-1:BitW]};
      res_old_d   = 1'b0;
      res_found_d = 1'b0;
      res_pos_d   = '0;
    end

    if (state_q == StBitWb) begin
      res_old_d = |(sel_word & bit_mask);
    end

    if (state_q == StScan) begin
      if (scan_issue) begin
        ptr_d   = ptr_q + (WselW + 1)'(1);
        pword_d = ptr_q[WselW-1:0];
      end
      // hold the pending flag off once this word ends the scan
      pend_d = scan_issue & ~scan_hit & ~scan_end;
      if (scan_hit && (scan_pos <= last_q)) begin
        res_found_d = 1'b1;
        res_pos_d   = scan_pos;
      end
    end
  end

  // Output register: load on completion, drop on transaction
  always_comb begin
    out_valid_d = out_valid_q;
    out_old_d   = out_old_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (res_load) begin
      out_valid_d = 1'b1;
      out_old_d   = res_old_q;
      out_found_d = res_found_q;
      out_pos_d   = res_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    sel_q       <= sel_d;
    idx_q       <= idx_d;
    last_q      <= last_d;
    ptr_q       <= ptr_d;
    pword_q     <= pword_d;
    res_old_q   <= res_old_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    out_old_q   <= out_old_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.old_bit  = out_old_q;
  assign out_o.found    = out_found_q;
  assign out_o.position = out_pos_q;

endmodule

// File: design/bscfn_store.sv
`timescale 1ns / 1ps

module bscfn_store
  import bscfn_pkg::*;
#(
  parameter int WORDS  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  mem_ctl_t          ctl_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WordW-1:0]  wr_data_i,
  output logic [WordW-1:0]  first_o,
  output logic [WordW-1:0]  second_o
);

  logic [WordW-1:0] first_mem  [WORDS];
  logic [WordW-1:0] second_mem [WORDS];
  logic [WordW-1:0] first_q;
  logic [WordW-1:0] second_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_first) begin
      first_mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.wr_second) begin
      second_mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      first_q  <= first_mem[rd_addr_i];
      second_q <= second_mem[rd_addr_i];
    end
  end

  assign first_o  = first_q;
  assign second_o = second_q;

endmodule
